/* src/assert_macros.svh */
// Assertion macros included by the detector core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/grsd_pkg.sv */
package grsd_pkg;

	localparam int WIN_DEPTH = 16;
	localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int WIN_CNT_W = $clog2(WIN_DEPTH + 1);
	localparam int WIN_SUM_W = WIN_IDX_W + 1;

	localparam int POS_W  = 24;
	localparam int TIME_W = 32;
	localparam int TOL_W  = 23;
	localparam int VEL_W  = 24;
	localparam int DUR_W  = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int US_W   = 20;
	localparam int LHS_W  = DIFF_W + US_W;
	localparam int RHS_W  = VEL_W + TIME_W;
	localparam int CFG_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [US_W-1:0]   US_PER_S    = 20'd1000000;
	localparam logic [TIME_W-1:0] SPAN_MIN_US = 32'd50000;

	localparam logic [TOL_W-1:0] TOL_RESET = 23'd5000;
	localparam logic [VEL_W-1:0] VEL_RESET = 24'd500;
	localparam logic [DUR_W-1:0] DUR_RESET = 32'd300000;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUR = 2'd2;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_START,
		OP_SAMPLE
	} op_t;

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [POS_W-1:0] sample_position;
		logic [TIME_W-1:0]       sample_time;
		logic signed [POS_W-1:0] goal_position;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] current_position;
		logic                    goal_reached;
		logic                    goal_stalled;
		logic                    holding_object;
		logic                    goal_running;
		logic                    position_seen;
	} out_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    running;
		logic                    seen;
	} status_t;

	typedef struct packed {
		op_t               op;
		logic              reached;
		logic              span_ok;
		logic [TIME_W-1:0] span;
		logic [DIFF_W-1:0] pdiff;
		logic [TIME_W-1:0] now;
		status_t           status;
	} front_t;

	typedef struct packed {
		op_t               op;
		logic              reached;
		logic              span_ok;
		logic [LHS_W-1:0]  lhs;
		logic [RHS_W-1:0]  rhs;
		logic [TIME_W-1:0] now;
		status_t           status;
	} prod_t;

	function automatic logic [DIFF_W-1:0] abs_diff(
		input logic signed [POS_W-1:0] a,
		input logic signed [POS_W-1:0] b
	);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

endpackage

/* src/grsd_window.sv */
module grsd_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  grsd_pkg::in_t                  in_data,
	input  logic [grsd_pkg::TOL_W-1:0]     reach_tolerance,
	input  logic                           down_rdy,
	output logic                           valid_s2,
	output grsd_pkg::front_t               front_s2
);

	logic                                   valid_s1;
	grsd_pkg::in_t                          item_s1;
	logic                                   rdy_s1;
	logic                                   rdy_s2;
	logic                                   fire;

	logic [grsd_pkg::WIN_IDX_W-1:0]         head_q;
	logic [grsd_pkg::WIN_CNT_W-1:0]         count_q;
	logic signed [grsd_pkg::POS_W-1:0]      target_q;
	logic signed [grsd_pkg::POS_W-1:0]      last_pos_q;
	logic                                   running_q;
	logic                                   seen_q;
	logic [grsd_pkg::TIME_W-1:0]            win_time_q [grsd_pkg::WIN_DEPTH];
	logic signed [grsd_pkg::POS_W-1:0]      win_pos_q [grsd_pkg::WIN_DEPTH];

	logic                                   full;
	logic [grsd_pkg::WIN_IDX_W-1:0]         head_inc;
	logic [grsd_pkg::WIN_IDX_W-1:0]         head_n;
	logic [grsd_pkg::WIN_CNT_W-1:0]         cnt_pre;
	logic [grsd_pkg::WIN_SUM_W-1:0]         slot_sum;
	logic [grsd_pkg::WIN_SUM_W-1:0]         slot_wrap;
	logic [grsd_pkg::WIN_IDX_W-1:0]         slot;
	logic                                   has_old;
	logic [grsd_pkg::TIME_W-1:0]            old_time;
	logic signed [grsd_pkg::POS_W-1:0]      old_pos;
	grsd_pkg::front_t                       front;

	assign rdy_s2   = !valid_s2 || down_rdy;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign fire     = valid_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign full     = (count_q == grsd_pkg::WIN_CNT_W'(grsd_pkg::WIN_DEPTH));
	assign head_inc = (head_q == grsd_pkg::WIN_IDX_W'(grsd_pkg::WIN_DEPTH - 1)) ? '0
		: head_q + 1'b1;
	assign head_n   = full ? head_inc : head_q;
	assign cnt_pre  = full ? grsd_pkg::WIN_CNT_W'(grsd_pkg::WIN_DEPTH - 1) : count_q;
	assign slot_sum = {1'b0, head_n} + {1'b0, cnt_pre[grsd_pkg::WIN_IDX_W-1:0]};
	assign slot_wrap = (slot_sum >= grsd_pkg::WIN_SUM_W'(grsd_pkg::WIN_DEPTH))
		? slot_sum - grsd_pkg::WIN_SUM_W'(grsd_pkg::WIN_DEPTH) : slot_sum;
	assign slot     = slot_wrap[grsd_pkg::WIN_IDX_W-1:0];
	assign has_old  = (cnt_pre != '0);
	assign old_time = has_old ? win_time_q[head_n] : item_s1.sample_time;
	assign old_pos  = has_old ? win_pos_q[head_n] : item_s1.sample_position;

	always_comb begin
		front.reached = grsd_pkg::abs_diff(item_s1.sample_position, target_q)
			<= grsd_pkg::DIFF_W'(reach_tolerance);
		front.span    = item_s1.sample_time - old_time;
		front.span_ok = has_old && (front.span > grsd_pkg::SPAN_MIN_US);
		front.pdiff   = grsd_pkg::abs_diff(item_s1.sample_position, old_pos);
		front.now     = item_s1.sample_time;
		front.op      = grsd_pkg::OP_PASS;
		front.status.position = last_pos_q;
		front.status.running  = running_q;
		front.status.seen     = seen_q;
		unique case (item_s1.cmd)
			grsd_pkg::CMD_SAMPLE: begin
				front.op = running_q ? grsd_pkg::OP_SAMPLE : grsd_pkg::OP_PASS;
				front.status.position = item_s1.sample_position;
				front.status.seen     = 1'b1;
			end
			grsd_pkg::CMD_START: begin
				front.op = grsd_pkg::OP_START;
				front.status.running = 1'b1;
			end
			grsd_pkg::CMD_END: begin
				front.status.running = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			target_q   <= '0;
			last_pos_q <= '0;
			running_q  <= 1'b0;
			seen_q     <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				unique case (item_s1.cmd)
					grsd_pkg::CMD_SAMPLE: begin
						last_pos_q <= item_s1.sample_position;
						seen_q     <= 1'b1;
						if (running_q) begin
							head_q  <= head_n;
							count_q <= cnt_pre + 1'b1;
						end
					end
					grsd_pkg::CMD_START: begin
						target_q  <= item_s1.goal_position;
						running_q <= 1'b1;
						head_q    <= '0;
						count_q   <= '0;
					end
					grsd_pkg::CMD_END: begin
						running_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			front_s2 <= front;
			if (item_s1.cmd == grsd_pkg::CMD_SAMPLE && running_q) begin
				win_time_q[slot] <= item_s1.sample_time;
				win_pos_q[slot]  <= item_s1.sample_position;
			end
		end
	end

endmodule

/* src/grsd_mult.sv */
module grsd_mult (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s2,
	input  grsd_pkg::front_t           front_s2,
	input  logic [grsd_pkg::VEL_W-1:0] stall_velocity_limit,
	output logic                       rdy_s3,
	input  logic                       down_rdy,
	output logic                       valid_s3,
	output grsd_pkg::prod_t            prod_s3
);

	grsd_pkg::prod_t prod;

	assign rdy_s3 = !valid_s3 || down_rdy;

	always_comb begin
		prod.op      = front_s2.op;
		prod.reached = front_s2.reached;
		prod.span_ok = front_s2.span_ok;
		prod.lhs     = grsd_pkg::LHS_W'(front_s2.pdiff) * grsd_pkg::LHS_W'(grsd_pkg::US_PER_S);
		prod.rhs     = grsd_pkg::RHS_W'(stall_velocity_limit)
			* grsd_pkg::RHS_W'(front_s2.span);
		prod.now     = front_s2.now;
		prod.status  = front_s2.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			prod_s3 <= prod;
		end
	end

endmodule

/* src/grsd_decide.sv */
module grsd_decide (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s3,
	input  grsd_pkg::prod_t             prod_s3,
	input  logic [grsd_pkg::DUR_W-1:0]  stall_duration,
	output logic                        rdy_out,
	output logic                        out_valid,
	input  logic                        out_stall,
	output grsd_pkg::out_t              out_data
);

	logic                        reached_q;
	logic                        stalled_q;
	logic                        holding_q;
	logic                        armed_q;
	logic [grsd_pkg::TIME_W-1:0] since_q;
	logic                        out_valid_q;
	grsd_pkg::out_t              out_q;

	logic                        reached_n;
	logic                        stalled_n;
	logic                        holding_n;
	logic                        armed_n;
	logic [grsd_pkg::TIME_W-1:0] since_n;
	logic                        fire;
	grsd_pkg::out_t              result;

	assign rdy_out   = !out_valid_q || !out_stall;
	assign fire      = valid_s3 && rdy_out;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		reached_n = reached_q;
		stalled_n = stalled_q;
		holding_n = holding_q;
		armed_n   = armed_q;
		since_n   = since_q;
		case (prod_s3.op)
			grsd_pkg::OP_START: begin
				reached_n = 1'b0;
				stalled_n = 1'b0;
				holding_n = 1'b0;
				armed_n   = 1'b0;
				since_n   = '0;
			end
			grsd_pkg::OP_SAMPLE: begin
				if (prod_s3.reached) begin
					reached_n = 1'b1;
					stalled_n = 1'b0;
					holding_n = 1'b0;
				end else if (prod_s3.span_ok) begin
					if (grsd_pkg::RHS_W'(prod_s3.lhs) < prod_s3.rhs) begin
						if (!armed_q) begin
							armed_n = 1'b1;
							since_n = prod_s3.now;
						end else if ((prod_s3.now - since_q) >= stall_duration) begin
							stalled_n = 1'b1;
							holding_n = 1'b1;
						end
					end else begin
						armed_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		result.current_position = prod_s3.status.position;
		result.goal_reached     = reached_n;
		result.goal_stalled     = stalled_n;
		result.holding_object   = holding_n;
		result.goal_running     = prod_s3.status.running;
		result.position_seen    = prod_s3.status.seen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q   <= 1'b0;
			stalled_q   <= 1'b0;
			holding_q   <= 1'b0;
			armed_q     <= 1'b0;
			since_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_out) begin
				out_valid_q <= valid_s3;
			end
			if (fire) begin
				reached_q <= reached_n;
				stalled_q <= stalled_n;
				holding_q <= holding_n;
				armed_q   <= armed_n;
				since_q   <= since_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

endmodule

/* src/gripper_stall_reach_detector_core.sv */
// Gripper stall and reach detector. Each input beat is a position sample, a goal start or a
// goal end, and each produces exactly one result beat with the last position and the status
// flags. One beat is accepted per cycle while in_stall is low; a result passes in order
// through the register stages after the input register: the window update and distance
// stage, the speed cross-multiplication stage, and the decision stage that drives the
// output register. While the output is stalled, up to four beats are buffered before the
// input stalls. Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
`include "assert_macros.svh"

module gripper_stall_reach_detector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  grsd_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output grsd_pkg::out_t                 out_data,
	input  logic                           cfg_we,
	input  logic [grsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grsd_pkg::CFG_W-1:0]     cfg_data
);

	logic [grsd_pkg::TOL_W-1:0] tol_q;
	logic [grsd_pkg::VEL_W-1:0] vel_q;
	logic [grsd_pkg::DUR_W-1:0] dur_q;

	logic                       valid_s2;
	grsd_pkg::front_t           front_s2;
	logic                       rdy_s3;
	logic                       valid_s3;
	grsd_pkg::prod_t            prod_s3;
	logic                       rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= grsd_pkg::TOL_RESET;
			vel_q <= grsd_pkg::VEL_RESET;
			dur_q <= grsd_pkg::DUR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grsd_pkg::REG_TOL: tol_q <= cfg_data[grsd_pkg::TOL_W-1:0];
				grsd_pkg::REG_VEL: vel_q <= cfg_data[grsd_pkg::VEL_W-1:0];
				grsd_pkg::REG_DUR: dur_q <= cfg_data[grsd_pkg::DUR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	grsd_window u_window (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.reach_tolerance (tol_q),
		.down_rdy        (rdy_s3),
		.valid_s2        (valid_s2),
		.front_s2        (front_s2)
	);

	grsd_mult u_mult (
		.clk                  (clk),
		.arst_n               (arst_n),
		.valid_s2             (valid_s2),
		.front_s2             (front_s2),
		.stall_velocity_limit (vel_q),
		.rdy_s3               (rdy_s3),
		.down_rdy             (rdy_out),
		.valid_s3             (valid_s3),
		.prod_s3              (prod_s3)
	);

	grsd_decide u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s3       (valid_s3),
		.prod_s3        (prod_s3),
		.stall_duration (dur_q),
		.rdy_out        (rdy_out),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

	`ASSERT_IMPLIES(a_stall_holds_together, clk, arst_n, out_valid, out_data.goal_stalled == out_data.holding_object)
	`ASSERT_IMPLIES(a_pos_zero_unseen, clk, arst_n, out_valid && !out_data.position_seen, out_data.current_position == '0)
	`ASSERT_IMPLIES(a_holding_needs_sample, clk, arst_n, out_valid && out_data.holding_object, out_data.position_seen)
	`ASSERT_NEXT(a_seen_sticky, clk, arst_n, out_valid && out_data.position_seen, !out_valid || out_data.position_seen)

endmodule
